// ----- rtl/core/tbw_pkg.sv -----
// ----------------------------------------------------------------------------
// tbw_pkg
// Shared types and constants of the barycentric weight block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbw_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int WEIGHT_W    = 32;
    localparam int QUOT_BITS   = WEIGHT_W - 1;
    localparam int DIV_LAT     = QUOT_BITS + 2;

    localparam logic signed [WEIGHT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/tbw_queue.sv -----
// ----------------------------------------------------------------------------
// tbw_queue
// Short FIFO between the front and back parts, first-word fall-through.
// ----------------------------------------------------------------------------
`default_nettype none

module tbw_queue #(
    parameter int W = 180
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [W-1:0]        wdata,
    input  logic                pop,
    output logic [W-1:0]        rdata,
    output tbw_pkg::queue_stat_t stat
);
    import tbw_pkg::*;

    logic [W-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.count = cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tbw_front.sv -----
// ----------------------------------------------------------------------------
// tbw_front
// Accepts items, forms edge and offset vectors and the five dot products.
// ----------------------------------------------------------------------------
`default_nettype none

module tbw_front #(
    parameter int CB = 16,
    parameter int DW = 2 * CB + 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((12*CB+7)/8)*8-1:0]   s_tdata,
    input  tbw_pkg::queue_stat_t         q_stat,
    output logic                         q_push,
    output logic [5*DW-1:0]              q_wdata
);
    import tbw_pkg::*;

    localparam int EW = CB + 1;
    localparam int PW = 2 * CB + 2;

    logic signed [CB-1:0] c [12];
    logic signed [EW-1:0] e0_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] v_reg  [3];
    logic                 vf1_reg;
    logic                 vf2_reg;
    logic signed [PW-1:0] p00 [3];
    logic signed [PW-1:0] p01 [3];
    logic signed [PW-1:0] p11 [3];
    logic signed [PW-1:0] p20 [3];
    logic signed [PW-1:0] p21 [3];
    logic signed [DW-1:0] d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;
    logic [QCNT_W-1:0]    occ;
    logic                 take;

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            c[k] = $signed(s_tdata[k*CB +: CB]);
        end
    end

    assign occ      = q_stat.count + QCNT_W'(vf1_reg) + QCNT_W'(vf2_reg);
    assign s_tready = (occ < QCNT_W'(QUEUE_DEPTH));
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
        end else begin
            vf1_reg <= take;
            vf2_reg <= vf1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            e0_reg[k] <= EW'(c[6+k]) - EW'(c[3+k]);
            e1_reg[k] <= EW'(c[9+k]) - EW'(c[3+k]);
            v_reg[k]  <= EW'(c[k])   - EW'(c[3+k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p00[k] = e0_reg[k] * e0_reg[k];
            p01[k] = e0_reg[k] * e1_reg[k];
            p11[k] = e1_reg[k] * e1_reg[k];
            p20[k] = v_reg[k]  * e0_reg[k];
            p21[k] = v_reg[k]  * e1_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        d00_reg <= DW'(p00[0]) + DW'(p00[1]) + DW'(p00[2]);
        d01_reg <= DW'(p01[0]) + DW'(p01[1]) + DW'(p01[2]);
        d11_reg <= DW'(p11[0]) + DW'(p11[1]) + DW'(p11[2]);
        d20_reg <= DW'(p20[0]) + DW'(p20[1]) + DW'(p20[2]);
        d21_reg <= DW'(p21[0]) + DW'(p21[1]) + DW'(p21[2]);
    end

    assign q_push  = vf2_reg;
    assign q_wdata = {d21_reg, d20_reg, d11_reg, d01_reg, d00_reg};

endmodule

`default_nettype wire

// ----- rtl/core/tbw_mul.sv -----
// ----------------------------------------------------------------------------
// tbw_mul
// Two-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module tbw_mul #(
    parameter int W = 36
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    localparam int H  = W / 2;
    localparam int HW = W - H;
    localparam int PW = 2 * W;

    logic [H-1:0]            al, bl;
    logic signed [HW-1:0]    ah, bh;
    logic [2*H-1:0]          ll_reg;
    logic signed [H+HW:0]    lh_reg;
    logic signed [H+HW:0]    hl_reg;
    logic signed [2*HW-1:0]  hh_reg;
    logic signed [PW-1:0]    p_reg;

    assign al = a[H-1:0];
    assign bl = b[H-1:0];
    assign ah = a[W-1:H];
    assign bh = b[W-1:H];

    always_ff @(posedge aclk) begin
        if (ce) begin
            ll_reg <= al * bl;
            lh_reg <= $signed({1'b0, al}) * bh;
            hl_reg <= ah * $signed({1'b0, bl});
            hh_reg <= ah * bh;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg <= (PW'(hh_reg) <<< (2 * H)) + (PW'(lh_reg) <<< H)
                   + (PW'(hl_reg) <<< H) + PW'(ll_reg);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tbw_div.sv -----
// ----------------------------------------------------------------------------
// tbw_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tbw_div #(
    parameter int MW = 73,
    parameter int WF = 16
) (
    input  logic                                  aclk,
    input  logic                                  ce,
    input  logic [MW-1:0]                         num_mag,
    input  logic                                  num_neg,
    input  logic [MW-1:0]                         den,
    output logic signed [tbw_pkg::WEIGHT_W-1:0]   weight
);
    import tbw_pkg::*;

    localparam int CW = MW + WF + WEIGHT_W;
    localparam int QB = QUOT_BITS;

    logic [CW-1:0] rem_reg [QB+1];
    logic [MW-1:0] den_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          sat_reg [QB+1];
    logic          neg_reg [QB+1];
    logic [CW-1:0] trial   [QB+1];
    logic          ge      [QB+1];
    logic [CW-1:0] nshift;
    logic signed [WEIGHT_W-1:0] w_reg;

    assign nshift = CW'(num_mag) << WF;

    always_comb begin
        trial[0] = '0;
        ge[0]    = 1'b0;
        for (int j = 1; j <= QB; j++) begin
            trial[j] = CW'(den_reg[j-1]) << (QB - j);
            ge[j]    = (rem_reg[j-1] >= trial[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= nshift;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= (nshift >= (CW'(den) << QB));
            neg_reg[0] <= num_neg;
            for (int j = 1; j <= QB; j++) begin
                rem_reg[j] <= ge[j] ? rem_reg[j-1] - trial[j] : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (QB'(ge[j]) << (QB - j));
                sat_reg[j] <= sat_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
            if (sat_reg[QB]) begin
                w_reg <= neg_reg[QB] ? W_MIN : W_MAX;
            end else if (neg_reg[QB]) begin
                w_reg <= WEIGHT_W'(0) - {1'b0, q_reg[QB]};
            end else begin
                w_reg <= {1'b0, q_reg[QB]};
            end
        end
    end

    assign weight = w_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tbw_back.sv -----
// ----------------------------------------------------------------------------
// tbw_back
// Determinant, numerators, two dividers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbw_back #(
    parameter int DW = 36,
    parameter int WF = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [5*DW-1:0]              q_rdata,
    input  tbw_pkg::queue_stat_t         q_stat,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [3*tbw_pkg::WEIGHT_W-1:0] m_tdata,
    output logic                         m_tuser
);
    import tbw_pkg::*;

    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int LAST = 4 + DIV_LAT;

    logic                 ce;
    logic                 vld_reg [LAST+1];
    logic signed [DW-1:0] d_reg   [5];
    logic signed [PW-1:0] p_det0, p_det1, p_n10, p_n11, p_n20, p_n21;
    logic signed [NW-1:0] det_reg, n1_reg, n2_reg;
    logic [NW-1:0]        detm_reg, n1m_reg, n2m_reg;
    logic                 n1neg_reg, n2neg_reg, deg4_reg;
    logic                 deg_reg [DIV_LAT];
    logic signed [WEIGHT_W-1:0] w1, w2;
    logic signed [WEIGHT_W+1:0] w0_wide;
    logic signed [WEIGHT_W-1:0] w0;
    logic                 m_tvalid_reg;
    logic [3*WEIGHT_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    assign ce    = !m_tvalid_reg || m_tready;
    assign q_pop = ce && !q_stat.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= !q_stat.empty;
            for (int k = 1; k <= LAST; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_tvalid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 5; k++) begin
                d_reg[k] <= $signed(q_rdata[k*DW +: DW]);
            end
        end
    end

    // d_reg: 0 d00, 1 d01, 2 d11, 3 d20, 4 d21
    tbw_mul #(.W(DW)) u_mul_det0 (.aclk(aclk), .ce(ce), .a(d_reg[0]), .b(d_reg[2]), .p(p_det0));
    tbw_mul #(.W(DW)) u_mul_det1 (.aclk(aclk), .ce(ce), .a(d_reg[1]), .b(d_reg[1]), .p(p_det1));
    tbw_mul #(.W(DW)) u_mul_n10  (.aclk(aclk), .ce(ce), .a(d_reg[2]), .b(d_reg[3]), .p(p_n10));
    tbw_mul #(.W(DW)) u_mul_n11  (.aclk(aclk), .ce(ce), .a(d_reg[1]), .b(d_reg[4]), .p(p_n11));
    tbw_mul #(.W(DW)) u_mul_n20  (.aclk(aclk), .ce(ce), .a(d_reg[0]), .b(d_reg[4]), .p(p_n20));
    tbw_mul #(.W(DW)) u_mul_n21  (.aclk(aclk), .ce(ce), .a(d_reg[1]), .b(d_reg[3]), .p(p_n21));

    always_ff @(posedge aclk) begin
        if (ce) begin
            det_reg <= NW'(p_det0) - NW'(p_det1);
            n1_reg  <= NW'(p_n10) - NW'(p_n11);
            n2_reg  <= NW'(p_n20) - NW'(p_n21);

            detm_reg  <= det_reg;
            deg4_reg  <= (det_reg == '0) || det_reg[NW-1];
            n1neg_reg <= n1_reg[NW-1];
            n2neg_reg <= n2_reg[NW-1];
            n1m_reg   <= n1_reg[NW-1] ? NW'(0) - n1_reg : n1_reg;
            n2m_reg   <= n2_reg[NW-1] ? NW'(0) - n2_reg : n2_reg;

            deg_reg[0] <= deg4_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    tbw_div #(.MW(NW), .WF(WF)) u_div1 (
        .aclk(aclk), .ce(ce), .num_mag(n1m_reg), .num_neg(n1neg_reg),
        .den(detm_reg), .weight(w1)
    );
    tbw_div #(.MW(NW), .WF(WF)) u_div2 (
        .aclk(aclk), .ce(ce), .num_mag(n2m_reg), .num_neg(n2neg_reg),
        .den(detm_reg), .weight(w2)
    );

    always_comb begin
        w0_wide = ((WEIGHT_W+2)'(1) <<< WF) - (WEIGHT_W+2)'(w1) - (WEIGHT_W+2)'(w2);
        if (w0_wide > (WEIGHT_W+2)'(W_MAX)) begin
            w0 = W_MAX;
        end else if (w0_wide < (WEIGHT_W+2)'(W_MIN)) begin
            w0 = W_MIN;
        end else begin
            w0 = w0_wide[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce && vld_reg[LAST]) begin
            m_tuser_reg <= deg_reg[DIV_LAT-1];
            if (deg_reg[DIV_LAT-1]) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {w2, w1, w0};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- rtl/core/triangle_barycentric_weights.sv -----
// Throughput: one item per cycle while the output is not stalled; set by the divider pipelines and the queue.
// The front part runs freely and admits items only while the 4-entry queue has room.
// Output stall freezes the whole back pipeline through one clock enable.
// Reset (aresetn low, synchronous) empties the queue and clears all valid flags.
// ----------------------------------------------------------------------------
// triangle_barycentric_weights
// Barycentric weights of a point against a 3-D triangle, Q15.16 saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_barycentric_weights #(
    parameter int COORD_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // point_x, point_y, point_z, first_x..z, second_x..z, third_x..z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // weight_first, weight_second, weight_third
    output logic [3*tbw_pkg::WEIGHT_W-1:0]        m_tdata,
    // degenerate
    output logic                                  m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready
);
    import tbw_pkg::*;

    localparam int DW = 2 * COORD_BITS + 4;

    queue_stat_t       q_stat;
    logic              q_push;
    logic              q_pop;
    logic [5*DW-1:0]   q_wdata;
    logic [5*DW-1:0]   q_rdata;

    tbw_front #(.CB(COORD_BITS), .DW(DW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_stat(q_stat), .q_push(q_push), .q_wdata(q_wdata)
    );

    tbw_queue #(.W(5 * DW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .wdata(q_wdata), .pop(q_pop), .rdata(q_rdata),
        .stat(q_stat)
    );

    tbw_back #(.DW(DW), .WF(WEIGHT_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_rdata(q_rdata), .q_stat(q_stat), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result carries nonzero weights");

endmodule

`default_nettype wire
